FILE: src/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

    // entry buffer and code geometry
    localparam int unsigned MAX_KEYS_DEF = 8;
    localparam int unsigned CODE_KEYS    = 8;
    localparam int unsigned CODE_W       = 4 * CODE_KEYS;
    localparam int unsigned CFG_IDX_W    = 3;

    // key codes
    localparam logic [3:0] KEY_HASH = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_USER_CODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CODE_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_CODE_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_TRIES      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_TRIES    = 3'd5;

    // configuration reset values
    localparam logic [CODE_W-1:0] RST_USER_CODE       = 32'h0000_5999;
    localparam logic [3:0]        RST_USER_CODE_LEN   = 4'd4;
    localparam logic [CODE_W-1:0] RST_MASTER_CODE     = 32'h5544_9988;
    localparam logic [3:0]        RST_MASTER_CODE_LEN = 4'd8;
    localparam logic [3:0]        RST_USER_TRIES      = 4'd3;
    localparam logic [3:0]        RST_MASTER_TRIES    = 4'd2;

    // result status codes
    typedef enum logic [3:0] {
        ST_STORED       = 4'd0,
        ST_IGNORED      = 4'd1,
        ST_UNLOCKED     = 4'd2,
        ST_MASTER_OK    = 4'd3,
        ST_WRONG        = 4'd4,
        ST_MASTER_MODE  = 4'd5,
        ST_WRONG_MASTER = 4'd6,
        ST_LOCKED       = 4'd7,
        ST_RESET        = 4'd8
    } status_t;

    // configuration seen by the lock core
    typedef struct packed {
        logic [CODE_W-1:0] user_code;
        logic [3:0]        user_code_len;
        logic [CODE_W-1:0] master_code;
        logic [3:0]        master_code_len;
        logic [3:0]        user_tries;
        logic [3:0]        master_tries;
    } cfg_t;

    // one result word
    typedef struct packed {
        status_t    status;
        logic [3:0] tries_left;
        logic [3:0] master_left;
        logic       master_mode;
        logic       locked;
        logic [3:0] keys_held;
        logic       green;
    } result_t;

endpackage

FILE: src/keypad_code_lock.sv
`timescale 1ns / 1ps
// Path: a word accepted into the input register passes through the lock core into the result
// register, which shows its result; a stalled output can hold the word in the input register.
// Throughput: one word per cycle; the lock state loop closes through one compare and update.
// A stalled output holds its result and stops the input register, ready follows it.
// Reset (rst_n, async low): lock state, counters and config registers return to defaults;
// the entry buffer is not reset and needs no clearing pass.
module keypad_code_lock #(
    parameter int unsigned MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [3:0]                     key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [3:0]                     status,
    output logic [3:0]                     tries_left_out,
    output logic [3:0]                     master_left_out,
    output logic                           in_master_mode,
    output logic                           is_locked,
    output logic [3:0]                     keys_held,
    output logic                           green_on,
    input  logic                           cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kcl_pkg::CODE_W-1:0]     cfg_data
);
    import kcl_pkg::*;

    cfg_t       cfg;
    result_t    res;
    result_t    out_reg;
    logic       in_valid_reg;
    logic       cmd_reg;
    logic [3:0] key_reg;
    logic       out_valid_reg;
    logic       step;

    kcl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kcl_core #(
        .MAX_KEYS (MAX_KEYS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_reg),
        .key   (key_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // advance when the result slot is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign tries_left_out  = out_reg.tries_left;
    assign master_left_out = out_reg.master_left;
    assign in_master_mode  = out_reg.master_mode;
    assign is_locked       = out_reg.locked;
    assign keys_held       = out_reg.keys_held;
    assign green_on        = out_reg.green;

endmodule

FILE: src/kcl_cfg_regs.sv
`timescale 1ns / 1ps

module kcl_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kcl_pkg::CODE_W-1:0]         cfg_data,
    output kcl_pkg::cfg_t                      cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_code       <= RST_USER_CODE;
            cfg_reg.user_code_len   <= RST_USER_CODE_LEN;
            cfg_reg.master_code     <= RST_MASTER_CODE;
            cfg_reg.master_code_len <= RST_MASTER_CODE_LEN;
            cfg_reg.user_tries      <= RST_USER_TRIES;
            cfg_reg.master_tries    <= RST_MASTER_TRIES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_USER_CODE:       cfg_reg.user_code       <= cfg_data;
                REG_USER_CODE_LEN:   cfg_reg.user_code_len   <= cfg_data[3:0];
                REG_MASTER_CODE:     cfg_reg.master_code     <= cfg_data;
                REG_MASTER_CODE_LEN: cfg_reg.master_code_len <= cfg_data[3:0];
                REG_USER_TRIES:      cfg_reg.user_tries      <= cfg_data[3:0];
                REG_MASTER_TRIES:    cfg_reg.master_tries    <= cfg_data[3:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/kcl_match.sv
`timescale 1ns / 1ps

module kcl_match #(
    parameter int unsigned MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic [MAX_KEYS-1:0][3:0]            keys,
    input  logic [$clog2(MAX_KEYS+1)-1:0]       count,
    input  logic                                overflow,
    input  logic [kcl_pkg::CODE_W-1:0]          code,
    input  logic [3:0]                          len,
    output logic                                match
);
    import kcl_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_KEYS + 1);
    localparam int unsigned XW   = CW + 4;
    localparam int unsigned NCMP = (MAX_KEYS < CODE_KEYS) ? MAX_KEYS : CODE_KEYS;

    logic mismatch;
    logic len_ok;

    // per-key compare, only positions below the code length count
    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < NCMP; i++)
        begin
            if ((len > 4'(i)) && (keys[i] != code[4*i +: 4]))
            begin
                mismatch = 1'b1;
            end
        end
    end

    // code longer than eight keys never matches
    assign len_ok = (len <= 4'(CODE_KEYS)) && (XW'(count) == XW'(len));
    assign match  = len_ok && !overflow && !mismatch;

endmodule

FILE: src/kcl_core.sv
`timescale 1ns / 1ps

module kcl_core #(
    parameter int unsigned MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              cmd,
    input  logic [3:0]        key,
    input  kcl_pkg::cfg_t     cfg,
    output kcl_pkg::result_t  res
);
    import kcl_pkg::*;

    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam int unsigned IW = $clog2(MAX_KEYS);
    localparam int unsigned XW = CW + 4;

    logic [3:0]          keys_reg [MAX_KEYS];
    logic [MAX_KEYS-1:0][3:0] keys_flat;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [3:0]          tries_reg, tries_next;
    logic [3:0]          mleft_reg, mleft_next;
    logic                mm_reg, mm_next;
    logic                lock_reg, lock_next;
    logic                wr_en;
    logic                match;
    logic                master_full;
    logic                user_full;
    status_t             status;

    // flatten the entry buffer for the comparator
    always_comb
    begin
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            keys_flat[i] = keys_reg[i];
        end
    end

    kcl_match #(
        .MAX_KEYS (MAX_KEYS)
    ) u_match (
        .keys     (keys_flat),
        .count    (count_reg),
        .overflow (ovf_reg),
        .code     (mm_reg ? cfg.master_code : cfg.user_code),
        .len      (mm_reg ? cfg.master_code_len : cfg.user_code_len),
        .match    (match)
    );

    assign master_full = (XW'(count_reg) >= XW'(cfg.master_code_len))
                      || (count_reg == CW'(MAX_KEYS));
    assign user_full   = (count_reg == CW'(MAX_KEYS));

    // next state and status for the word in the input register
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        tries_next = tries_reg;
        mleft_next = mleft_reg;
        mm_next    = mm_reg;
        lock_next  = lock_reg;
        wr_en      = 1'b0;
        status     = ST_STORED;

        priority if (cmd)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            tries_next = cfg.user_tries;
            mleft_next = cfg.master_tries;
            mm_next    = 1'b0;
            lock_next  = 1'b0;
            status     = ST_RESET;
        end
        else if (lock_reg)
        begin
            status = ST_IGNORED;
        end
        else if (key == KEY_HASH)
        begin
            if (match)
            begin
                tries_next = cfg.user_tries;
                mleft_next = cfg.master_tries;
                mm_next    = 1'b0;
                lock_next  = 1'b0;
                status     = mm_reg ? ST_MASTER_OK : ST_UNLOCKED;
            end
            else if (mm_reg)
            begin
                if (mleft_reg <= 4'd1)
                begin
                    mleft_next = '0;
                    lock_next  = 1'b1;
                    status     = ST_LOCKED;
                end
                else
                begin
                    mleft_next = mleft_reg - 4'd1;
                    status     = ST_WRONG_MASTER;
                end
            end
            else
            begin
                if (tries_reg <= 4'd1)
                begin
                    tries_next = '0;
                    mm_next    = 1'b1;
                    status     = ST_MASTER_MODE;
                end
                else
                begin
                    tries_next = tries_reg - 4'd1;
                    status     = ST_WRONG;
                end
            end
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (mm_reg)
        begin
            if (master_full)
            begin
                status = ST_IGNORED;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            // full buffer in normal mode poisons the entry
            if (user_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
    end

    // lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            tries_reg <= RST_USER_TRIES;
            mleft_reg <= RST_MASTER_TRIES;
            mm_reg    <= 1'b0;
            lock_reg  <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            tries_reg <= tries_next;
            mleft_reg <= mleft_next;
            mm_reg    <= mm_next;
            lock_reg  <= lock_next;
        end
    end

    // entry buffer, only slots below the count are ever read
    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            keys_reg[count_reg[IW-1:0]] <= key;
        end
    end

    // result word
    always_comb
    begin
        res.status      = status;
        res.tries_left  = tries_next;
        res.master_left = mleft_next;
        res.master_mode = mm_next;
        res.locked      = lock_next;
        res.keys_held   = 4'(count_next);
        res.green       = !mm_next && !lock_next;
    end

endmodule

FILE: src/kcl_checker.sv
`timescale 1ns / 1ps

module kcl_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] status,
    input  logic [3:0] tries_left_out,
    input  logic [3:0] master_left_out,
    input  logic       in_master_mode,
    input  logic       is_locked,
    input  logic [3:0] keys_held,
    input  logic       green_on
);
    import kcl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(keys_held))
        else $error("result word changed while stalled");

    // green exactly when neither master mode nor lockout holds
    a_green: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (green_on == !(in_master_mode || is_locked)))
        else $error("indicator disagrees with mode");

    // lockout only from master mode, with master tries used up
    a_lock_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_locked |-> in_master_mode && (master_left_out == 4'd0))
        else $error("lockout outside master mode");

    // master mode implies user tries used up
    a_mode_tries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_master_mode |-> (tries_left_out == 4'd0))
        else $error("master mode with user tries left");

    // reset command leaves normal mode, unlocked, with no keys held
    a_reset_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RESET) |-> !in_master_mode && !is_locked
            && (keys_held == 4'd0))
        else $error("reset command left state behind");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .tries_left_out  (tries_left_out),
    .master_left_out (master_left_out),
    .in_master_mode  (in_master_mode),
    .is_locked       (is_locked),
    .keys_held       (keys_held),
    .green_on        (green_on)
);
